@@ hdl/masked_byte_pattern_scanner_unit_defines.svh @@
// Assertion helpers for the masked byte pattern scanner checker.
// Each expects clk and arst_n in the scope where it is used.
`ifndef MASKED_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MBPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/mbps_pkg.sv @@
package mbps_pkg;

	localparam int MAX_PATTERN_BYTES = 24;
	localparam int ADDRESS_BITS      = 32;
	localparam int LEN_W             = 5;
	localparam int COUNT_W           = 32;
	localparam int OUT_ADDR_W        = 32;
	localparam int CFG_DATA_W        = 64;
	localparam int CFG_INDEX_W       = 3;
	localparam int OUTQ_DEPTH        = 4;
	localparam int OUTQ_PTR_W        = 2;
	localparam int OUTQ_CNT_W        = 3;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_MID  = 3'd1,
		REG_PATTERN_HIGH = 3'd2,
		REG_CARE_MASK    = 3'd3,
		REG_PATTERN_LEN  = 3'd4,
		REG_REPORT_ALL   = 3'd5,
		REG_BASE_ADDRESS = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [OUT_ADDR_W-1:0] match_address;
		logic                  found;
		logic [COUNT_W-1:0]    match_count;
		logic                  is_summary;
	} out_item_t;

	typedef struct packed {
		logic [8*MAX_PATTERN_BYTES-1:0] pattern;
		logic [MAX_PATTERN_BYTES-1:0]   care_mask;
		logic [LEN_W-1:0]               pattern_length;
		logic                           report_all;
		logic [ADDRESS_BITS-1:0]        base_address;
	} cfg_t;

	// Up to two results pushed into the output queue per processed byte
	typedef struct packed {
		logic      a_valid;
		out_item_t a;
		logic      b_valid;
		out_item_t b;
	} outq_push_t;

	// Clamp the configured length into 1..MAX_PATTERN_BYTES
	function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] res;
		res = len;
		if (len == '0)
			res = LEN_W'(1);
		else if (len > LEN_W'(MAX_PATTERN_BYTES))
			res = LEN_W'(MAX_PATTERN_BYTES);
		return res;
	endfunction

endpackage

@@ hdl/masked_byte_pattern_scanner_unit.sv @@
// Channel | Direction | Handshake           | Payload
// in      | in        | in_valid / in_stall   | in_data  (data_byte, last_byte)
// out     | out       | out_valid / out_stall | out_data (match_address, found,
//         |           |                       |           match_count, is_summary)
// cfg     | in        | cfg_write_en          | cfg_index, cfg_data
//
// One byte per cycle while the queue has room: a byte is held in the input
// register, where the window compare and the run counters update, then its
// results enter a four-entry output queue. A byte may yield two results
// (match and summary), drained one per cycle. arst_n resets the config, input
// valid, run state and queue. in_stall rises when the input register is held
// because the queue lacks room for two results; out_stall holds the queue head.
module masked_byte_pattern_scanner_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  mbps_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output mbps_pkg::out_item_t              out_data,
	input  logic                             cfg_write_en,
	input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mbps_pkg::*;

	cfg_t                    cfg;
	in_item_t                item_s1;
	logic                    valid_s1;
	logic                    room;
	logic                    process;
	logic                    accept;
	logic                    hit;
	logic                    match;
	logic [LEN_W-1:0]        len;
	logic [COUNT_W-1:0]      bytes_seen_q;
	logic [COUNT_W-1:0]      bytes_seen_next;
	logic [COUNT_W-1:0]      total_q;
	logic [COUNT_W-1:0]      total_next;
	logic [ADDRESS_BITS-1:0] first_addr_q;
	logic [ADDRESS_BITS-1:0] first_addr_next;
	logic                    have_q;
	logic                    have_next;
	logic [COUNT_W-1:0]      start;
	logic [ADDRESS_BITS-1:0] addr;
	outq_push_t              push;
	logic                    pop;

	mbps_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	// Hold the input register until the queue has room
	assign process  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (process)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= in_data;
	end

	mbps_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (process),
		.clear     (item_s1.last_byte),
		.data_byte (item_s1.data_byte),
		.cfg       (cfg),
		.hit       (hit)
	);

	// Update run counters for the byte in the input register
	assign len             = used_length(cfg.pattern_length);
	assign bytes_seen_next = (bytes_seen_q == '1) ? bytes_seen_q : bytes_seen_q + COUNT_W'(1);
	assign match           = hit && (bytes_seen_next >= COUNT_W'(len));
	assign start           = bytes_seen_next - COUNT_W'(len);
	assign addr            = cfg.base_address + ADDRESS_BITS'(start);
	assign total_next      = (match && (total_q != '1)) ? total_q + COUNT_W'(1) : total_q;
	assign have_next       = have_q || match;
	assign first_addr_next = (match && !have_q) ? addr : first_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			total_q      <= '0;
			have_q       <= 1'b0;
			first_addr_q <= '0;
		end else if (process) begin
			if (item_s1.last_byte) begin
				bytes_seen_q <= '0;
				total_q      <= '0;
				have_q       <= 1'b0;
				first_addr_q <= '0;
			end else begin
				bytes_seen_q <= bytes_seen_next;
				total_q      <= total_next;
				have_q       <= have_next;
				first_addr_q <= first_addr_next;
			end
		end
	end

	// Build the match report and the end-of-run summary
	always_comb begin
		push.a_valid         = process && match && cfg.report_all;
		push.a.match_address = OUT_ADDR_W'(addr);
		push.a.found         = 1'b1;
		push.a.match_count   = total_next;
		push.a.is_summary    = 1'b0;
		push.b_valid         = process && item_s1.last_byte;
		push.b.match_address = have_next ? OUT_ADDR_W'(first_addr_next) : '0;
		push.b.found         = have_next;
		push.b.match_count   = total_next;
		push.b.is_summary    = 1'b1;
	end

	assign pop = out_valid && !out_stall;

	mbps_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.room       (room),
		.head_valid (out_valid),
		.head       (out_data)
	);

endmodule

@@ hdl/mbps_cfg.sv @@
module mbps_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mbps_pkg::cfg_t                   cfg
);
	import mbps_pkg::*;

	cfg_t cfg_q;

	// Write one register per enabled cycle; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern        <= '0;
			cfg_q.care_mask      <= '1;
			cfg_q.pattern_length <= LEN_W'(1);
			cfg_q.report_all     <= 1'b0;
			cfg_q.base_address   <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:  cfg_q.pattern[63:0]    <= cfg_data;
				REG_PATTERN_MID:  cfg_q.pattern[127:64]  <= cfg_data;
				REG_PATTERN_HIGH: cfg_q.pattern[191:128] <= cfg_data;
				REG_CARE_MASK:    cfg_q.care_mask <= cfg_data[MAX_PATTERN_BYTES-1:0];
				REG_PATTERN_LEN:  cfg_q.pattern_length <= cfg_data[LEN_W-1:0];
				REG_REPORT_ALL:   cfg_q.report_all <= cfg_data[0];
				REG_BASE_ADDRESS: cfg_q.base_address <= cfg_data[ADDRESS_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/mbps_window.sv @@
module mbps_window (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  logic           clear,
	input  logic [7:0]     data_byte,
	input  mbps_pkg::cfg_t cfg,
	output logic           hit
);
	import mbps_pkg::*;

	logic [7:0]       window_q [MAX_PATTERN_BYTES];
	logic [7:0]       win_next [MAX_PATTERN_BYTES];
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] pos [MAX_PATTERN_BYTES];

	// Window as it stands once the new byte is in, newest at entry 0
	always_comb begin
		win_next[0] = data_byte;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++)
			win_next[k] = window_q[k-1];
	end

	// Compare each cared pattern byte with its aligned window byte
	assign len = used_length(cfg.pattern_length);

	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			pos[i] = len - LEN_W'(1) - LEN_W'(i);
			if ((LEN_W'(i) < len) && cfg.care_mask[i]) begin
				if (win_next[pos[i]] != cfg.pattern[8*i +: 8])
					hit = 1'b0;
			end
		end
	end

	// Advance the window per processed byte; drop it at end of run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN_BYTES; k++)
				window_q[k] <= '0;
		end else if (shift) begin
			for (int k = 0; k < MAX_PATTERN_BYTES; k++)
				window_q[k] <= clear ? 8'd0 : win_next[k];
		end
	end

endmodule

@@ hdl/mbps_outq.sv @@
module mbps_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbps_pkg::outq_push_t  push,
	input  logic                  pop,
	output logic                  room,
	output logic                  head_valid,
	output mbps_pkg::out_item_t   head
);
	import mbps_pkg::*;

	out_item_t              q_mem [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]  wr_ptr_q;
	logic [OUTQ_PTR_W-1:0]  rd_ptr_q;
	logic [OUTQ_CNT_W-1:0]  count_q;
	logic [OUTQ_PTR_W-1:0]  b_ptr;
	logic [OUTQ_CNT_W-1:0]  n_push;

	assign b_ptr  = wr_ptr_q + OUTQ_PTR_W'(push.a_valid);
	assign n_push = OUTQ_CNT_W'(push.a_valid) + OUTQ_CNT_W'(push.b_valid);

	// Store the pushed results in order
	always_ff @(posedge clk) begin
		if (push.a_valid)
			q_mem[wr_ptr_q] <= push.a;
		if (push.b_valid)
			q_mem[b_ptr] <= push.b;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(pop);
			count_q  <= count_q + n_push - OUTQ_CNT_W'(pop);
		end
	end

	// Room for a worst-case pair of results
	assign room       = count_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = q_mem[rd_ptr_q];

endmodule

@@ hdl/mbps_checker.sv @@
`include "masked_byte_pattern_scanner_unit_defines.svh"

module mbps_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input mbps_pkg::in_item_t               in_data,
	input logic                             out_valid,
	input logic                             out_stall,
	input mbps_pkg::out_item_t              out_data
);
	import mbps_pkg::*;

	// A stalled input transaction holds
	`MBPS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "input changed while stalled")

	// A stalled result transaction holds
	`MBPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output changed while stalled")

	// A per-match report always flags a match with a nonzero count
	`MBPS_ASSERT_SAME(a_report_found, out_valid && !out_data.is_summary, out_data.found && (out_data.match_count != '0), "match report without match")

	// Summary found agrees with the count
	`MBPS_ASSERT_SAME(a_summary_count, out_valid && out_data.is_summary, out_data.found == (out_data.match_count != '0), "summary found disagrees with count")

	// A summary without a match carries address zero
	`MBPS_ASSERT_SAME(a_summary_addr, out_valid && out_data.is_summary && !out_data.found, out_data.match_address == '0, "empty summary has nonzero address")

endmodule

bind masked_byte_pattern_scanner_unit mbps_checker u_mbps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.in_data      (in_data),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_data     (out_data)
);

@@ bench/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mbps_pkg::*;

	localparam int N_REGS         = REG_BASE_ADDRESS + 1;
	localparam int MAX_GAP        = 6;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES   = 1150;
	localparam int PHASE_BYTES    = 80;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      in_valid     = 1'b0;
	logic      in_stall;
	in_item_t  in_data      = '0;
	logic      out_valid;
	logic      out_stall    = 1'b0;
	out_item_t out_data;
	logic      cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Scanner registers as the predictor sees them (reset values)
	logic [63:0]                  cfg_pat [3] = '{64'h0, 64'h0, 64'h0};
	logic [MAX_PATTERN_BYTES-1:0] cfg_care       = '1;
	logic [LEN_W-1:0]             cfg_len        = LEN_W'(1);
	logic                         cfg_report_all = 1'b0;
	logic [31:0]                  cfg_base       = '0;

	// Per-image scan state of the predictor
	logic [7:0]  win_hist [MAX_PATTERN_BYTES];
	logic [31:0] run_bytes;
	logic [31:0] run_first_addr;
	logic        run_has_match;
	logic [31:0] run_match_cnt;

	logic [63:0] next_setup [N_REGS];
	out_item_t   pending_results [$];
	out_item_t   want;

	logic tx_throttle = 1'b1;
	logic rx_throttle = 1'b1;
	int   rx_wait = 0;
	int   idle_cycles = 0;
	int   errors = 0;
	int   n_bytes_sent = 0;
	int   n_scans = 0;
	int   n_setups = 0;
	int   n_results = 0;
	int   n_summaries = 0;

	masked_byte_pattern_scanner_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results still expected",
				$time, WATCHDOG_LIMIT, pending_results.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Check each result against the oldest prediction, then draw the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (out_data.is_summary === 1'b1)
				n_summaries++;
			if (pending_results.size() == 0) begin
				$display("%0t: result %h arrived with nothing expected", $time, out_data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.match_address !== want.match_address) begin
					$display("%0t: match_address expected %h, got %h", $time,
						want.match_address, out_data.match_address);
					errors++;
				end
				if (out_data.found !== want.found) begin
					$display("%0t: found expected %b, got %b", $time,
						want.found, out_data.found);
					errors++;
				end
				if (out_data.match_count !== want.match_count) begin
					$display("%0t: match_count expected %0d, got %0d", $time,
						want.match_count, out_data.match_count);
					errors++;
				end
				if (out_data.is_summary !== want.is_summary) begin
					$display("%0t: is_summary expected %b, got %b", $time,
						want.is_summary, out_data.is_summary);
					errors++;
				end
			end
			rx_wait = rx_throttle ? $urandom_range(0, MAX_GAP) : 0;
		end else if (rx_wait != 0) begin
			rx_wait--;
		end
		out_stall <= (rx_wait != 0);
	end

	function automatic void clear_run();
		for (int i = 0; i < MAX_PATTERN_BYTES; i++)
			win_hist[i] = '0;
		run_bytes      = '0;
		run_first_addr = '0;
		run_has_match  = 1'b0;
		run_match_cnt  = '0;
	endfunction

	// Clamp the programmed length into 1..MAX_PATTERN_BYTES
	function automatic int eff_len();
		if (cfg_len == '0)
			return 1;
		if (cfg_len > LEN_W'(MAX_PATTERN_BYTES))
			return MAX_PATTERN_BYTES;
		return int'(cfg_len);
	endfunction

	// Shift one image byte into the window and queue the results it causes
	function automatic void scan_byte(input logic [7:0] b, input logic last);
		int           len;
		logic         hit;
		logic [31:0]  addr;
		logic [191:0] pat;
		len = eff_len();
		pat = {cfg_pat[2], cfg_pat[1], cfg_pat[0]};
		for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--)
			win_hist[i] = win_hist[i-1];
		win_hist[0] = b;
		if (run_bytes != '1)
			run_bytes++;

		// Oldest byte of the window lines up with pattern byte 0
		hit = (run_bytes >= 32'(len));
		for (int i = 0; i < len; i++)
			if (cfg_care[i] && win_hist[len-1-i] != pat[8*i +: 8])
				hit = 1'b0;

		if (hit) begin
			addr = cfg_base + (run_bytes - 32'(len));
			if (run_match_cnt != '1)
				run_match_cnt++;
			if (!run_has_match) begin
				run_has_match  = 1'b1;
				run_first_addr = addr;
			end
			if (cfg_report_all)
				pending_results.push_back('{match_address: addr, found: 1'b1,
					match_count: run_match_cnt, is_summary: 1'b0});
		end

		if (last) begin
			pending_results.push_back('{
				match_address: run_has_match ? run_first_addr : 32'h0,
				found: run_has_match, match_count: run_match_cnt, is_summary: 1'b1});
			clear_run();
		end
	endfunction

	// Send one image byte after a random gap and predict on acceptance
	task automatic push_image_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_throttle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{data_byte: b, last_byte: last};
		do @(posedge clk); while (in_stall);
		scan_byte(b, last);
		n_bytes_sent++;
		if (last)
			n_scans++;
	endtask

	// Hold the input and wait until every predicted result has been checked
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Write all registers from next_setup once the block has gone quiet
	task automatic apply_config();
		cfg_reg_t idx;
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		idx = idx.first();
		do begin
			cfg_write_en <= 1'b1;
			cfg_index    <= idx;
			cfg_data     <= next_setup[idx];
			@(posedge clk);
			case (idx)
				REG_PATTERN_LOW:  cfg_pat[0]     = next_setup[idx];
				REG_PATTERN_MID:  cfg_pat[1]     = next_setup[idx];
				REG_PATTERN_HIGH: cfg_pat[2]     = next_setup[idx];
				REG_CARE_MASK:    cfg_care       = next_setup[idx][MAX_PATTERN_BYTES-1:0];
				REG_PATTERN_LEN:  cfg_len        = next_setup[idx][LEN_W-1:0];
				REG_REPORT_ALL:   cfg_report_all = next_setup[idx][0];
				REG_BASE_ADDRESS: cfg_base       = next_setup[idx][31:0];
				default: ;
			endcase
			idx = idx.next();
		end while (idx != idx.first());
		cfg_write_en <= 1'b0;
		n_setups++;
	endtask

	// Out of reset: length 1, pattern byte zero, first-match mode
	task automatic test_reset_defaults();
		push_image_byte(8'h00, 1'b0);
		push_image_byte(8'hFF, 1'b0);
		push_image_byte(8'h00, 1'b1);
	endtask

	// Wildcard middle byte, overlapping matches, address wrap, too few bytes
	task automatic test_wildcards_and_wrap();
		next_setup[REG_PATTERN_LOW]  = '0;
		next_setup[REG_PATTERN_MID]  = '0;
		next_setup[REG_PATTERN_HIGH] = '0;
		// care bits above the length are set and must be ignored
		next_setup[REG_CARE_MASK]    = 64'h0000_0000_00FF_FFF5;
		next_setup[REG_PATTERN_LEN]  = 64'd3;
		next_setup[REG_REPORT_ALL]   = 64'd1;
		next_setup[REG_BASE_ADDRESS] = 64'h0000_0000_FFFF_FFFF;
		apply_config();
		push_image_byte(8'h00, 1'b0);
		push_image_byte(8'h00, 1'b0);
		push_image_byte(8'h00, 1'b0);
		push_image_byte(8'h7E, 1'b0);
		push_image_byte(8'h00, 1'b0);
		push_image_byte(8'h00, 1'b1);
	endtask

	// Length zero acts as one; junk above each register's width; count in first-match mode
	task automatic test_length_clamp_first_match();
		next_setup[REG_PATTERN_LOW]  = 64'h0000_0000_0000_00FF;
		next_setup[REG_CARE_MASK]    = 64'hABCD_EF00_0000_0001;
		next_setup[REG_PATTERN_LEN]  = 64'hFFFF_FFFF_FFFF_FFE0;
		next_setup[REG_REPORT_ALL]   = 64'hFFFF_FFFF_FFFF_FFFE;
		next_setup[REG_BASE_ADDRESS] = 64'hFFFF_FFFF_1234_0000;
		apply_config();
		push_image_byte(8'hFF, 1'b0);
		push_image_byte(8'h00, 1'b0);
		push_image_byte(8'hFF, 1'b0);
		push_image_byte(8'h80, 1'b1);
		// image with no match at all
		push_image_byte(8'h00, 1'b1);
	endtask

	// Match completing on the last byte yields a report and then the summary
	task automatic test_match_on_last_byte();
		next_setup[REG_PATTERN_LOW]  = 64'h0000_0000_0000_5251;  // "QR"
		next_setup[REG_PATTERN_MID]  = '1;
		next_setup[REG_PATTERN_HIGH] = '1;
		next_setup[REG_CARE_MASK]    = '1;
		next_setup[REG_PATTERN_LEN]  = 64'd2;
		next_setup[REG_REPORT_ALL]   = 64'd1;
		next_setup[REG_BASE_ADDRESS] = '0;
		apply_config();
		push_image_byte(8'h51, 1'b0);
		push_image_byte(8'h52, 1'b1);
	endtask

	function automatic logic [63:0] rand_pattern_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Draw a register setting, leaning toward short patterns and the extremes
	task automatic pick_random_setup();
		int pick;
		int len;
		next_setup[REG_PATTERN_LOW]  = rand_pattern_word();
		next_setup[REG_PATTERN_MID]  = rand_pattern_word();
		next_setup[REG_PATTERN_HIGH] = rand_pattern_word();

		pick = $urandom_range(0, 5);
		if (pick < 2)
			next_setup[REG_CARE_MASK] = {$urandom, 8'($urandom), 24'hFF_FFFF};
		else if (pick == 2)
			next_setup[REG_CARE_MASK] = {$urandom, 8'($urandom), 24'h0};
		else
			next_setup[REG_CARE_MASK] = {$urandom, $urandom};

		pick = $urandom_range(0, 9);
		if (pick < 6)
			len = $urandom_range(1, 4);
		else if (pick < 8)
			len = $urandom_range(5, MAX_PATTERN_BYTES);
		else if (pick == 8)
			len = $urandom_range(0, 1) ? 0 : MAX_PATTERN_BYTES;
		else
			len = $urandom_range(MAX_PATTERN_BYTES + 1, 31);
		next_setup[REG_PATTERN_LEN] = {$urandom, 27'($urandom), 5'(len)};

		next_setup[REG_REPORT_ALL] = {$urandom, $urandom};

		pick = $urandom_range(0, 5);
		if (pick == 0)
			next_setup[REG_BASE_ADDRESS] = {$urandom, 32'h0};
		else if (pick == 1)
			next_setup[REG_BASE_ADDRESS] = {$urandom, 32'hFFFF_FFFF - $urandom_range(0, 40)};
		else
			next_setup[REG_BASE_ADDRESS] = {$urandom, $urandom};
	endtask

	// Images built mostly from pattern occurrences, with broken copies and noise
	task automatic test_random_scans();
		int           random_bytes;
		int           phase_bytes;
		int           run_len;
		int           len;
		int           pick;
		int           pos;
		logic [7:0]   img [$];
		logic [191:0] pat;
		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			pick_random_setup();
			apply_config();
			tx_throttle = ($urandom_range(0, 2) != 0);
			rx_throttle = ($urandom_range(0, 2) != 0);
			len = eff_len();
			pat = {cfg_pat[2], cfg_pat[1], cfg_pat[0]};
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				img.delete();
				run_len = $urandom_range(1, 3 * len + 6);
				while (img.size() < run_len) begin
					pick = $urandom_range(0, 9);
					if (pick < 6) begin
						// occurrence with random bytes in wildcard slots
						for (int j = 0; j < len; j++)
							img.push_back(cfg_care[j] ? pat[8*j +: 8] : 8'($urandom));
						if (pick == 5) begin
							pos = img.size() - 1 - $urandom_range(0, len - 1);
							img[pos] = img[pos] ^ 8'(1 << $urandom_range(0, 7));
						end
					end else if (pick < 9) begin
						img.push_back(pat[8*$urandom_range(0, len - 1) +: 8]);
					end else begin
						img.push_back(8'($urandom));
					end
				end
				for (int k = 0; k < img.size(); k++) begin
					push_image_byte(img[k], k == img.size() - 1);
					if ($urandom_range(0, 63) == 0)
						wait_results_drained();
				end
				phase_bytes += img.size();
			end
			random_bytes += phase_bytes;
		end
	endtask

	initial begin
		clear_run();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_wildcards_and_wrap();
		test_length_clamp_first_match();
		test_match_on_last_byte();
		test_random_scans();

		wait_results_drained();
		repeat (END_CYCLES) @(posedge clk);
		$display("Scanned %0d bytes in %0d images under %0d register settings,",
			n_bytes_sent, n_scans, n_setups);
		$display("checked %0d results (%0d summaries), %0d mismatches.",
			n_results, n_summaries, errors);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
